/* rtl/stt_pkg.sv */
// Types, codes and character-class helpers shared by the source text tokenizer.
package stt_pkg;

    localparam int POS_BITS = 16;         // internal offset width, 8..32
    localparam int OUT_POS_BITS = 16;     // reported offset width
    localparam int Q_DEPTH = 4;           // token queue depth, power of two, >= 2

    typedef logic [POS_BITS-1:0] pos_t;
    localparam pos_t POS_MAX = '1;

    // token kind codes as seen on the output
    typedef enum logic [3:0] {
        K_ERROR     = 4'd0,
        K_EOF       = 4'd1,
        K_NEWLINE   = 4'd2,
        K_LPAREN    = 4'd3,
        K_RPAREN    = 4'd4,
        K_LBRACKET  = 4'd5,
        K_RBRACKET  = 4'd6,
        K_LBRACE    = 4'd7,
        K_RBRACE    = 4'd8,
        K_COMMA     = 4'd9,
        K_SEMICOLON = 4'd10,
        K_LITERAL   = 4'd11,
        K_NUMBER    = 4'd12,
        K_SYMBOL    = 4'd13,
        K_OPCODE    = 4'd14
    } kind_t;

    // run token in progress
    typedef enum logic [2:0] {
        PK_NONE    = 3'd0,
        PK_LITERAL = 3'd1,
        PK_COMMENT = 3'd2,
        PK_NUMBER  = 3'd3,
        PK_SYMBOL  = 3'd4,
        PK_OPCODE  = 3'd5
    } pend_t;

    // byte classes
    typedef enum logic [4:0] {
        C_SPACE, C_LF, C_LPAREN, C_RPAREN, C_LBRACKET, C_RBRACKET,
        C_LBRACE, C_RBRACE, C_COMMA, C_SEMI, C_BSLASH, C_HASH,
        C_DIGIT, C_ALPHA, C_UNDER, C_OPCH, C_OTHER
    } cls_t;

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } char_beat_t;

    typedef struct packed {
        kind_t                   kind;
        logic [OUT_POS_BITS-1:0] begin_pos;
        logic [OUT_POS_BITS-1:0] end_pos;
        logic                    last;
    } tok_t;

    // tokens produced by one accepted byte, oldest first
    typedef struct packed {
        logic [1:0] count;
        tok_t       first;
        tok_t       second;
    } push_t;

    function automatic cls_t classify(input logic [7:0] ch);
        cls_t c;
        unique case (ch) inside
            CH_SPACE, CH_TAB: c = C_SPACE;
            CH_LF:            c = C_LF;
            CH_LPAREN:        c = C_LPAREN;
            CH_RPAREN:        c = C_RPAREN;
            CH_LBRACKET:      c = C_LBRACKET;
            CH_RBRACKET:      c = C_RBRACKET;
            CH_LBRACE:        c = C_LBRACE;
            CH_RBRACE:        c = C_RBRACE;
            CH_COMMA:         c = C_COMMA;
            CH_SEMI:          c = C_SEMI;
            CH_BSLASH:        c = C_BSLASH;
            CH_HASH:          c = C_HASH;
            CH_UNDER:         c = C_UNDER;
            [8'h30:8'h39]:    c = C_DIGIT;
            [8'h41:8'h5A], [8'h61:8'h7A]: c = C_ALPHA;
            // ! " $ % & ' * + - . / : < = > ? @ ^ ` | ~
            8'h21, 8'h22, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D,
            8'h2E, 8'h2F, 8'h3A, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5E,
            8'h60, 8'h7C, 8'h7E: c = C_OPCH;
            default:          c = C_OTHER;
        endcase
        return c;
    endfunction

    function automatic logic continues(input pend_t pk, input cls_t c);
        logic r;
        case (pk)
            PK_LITERAL: r = (c == C_DIGIT) || (c == C_ALPHA);
            PK_COMMENT: r = (c != C_LF);
            PK_NUMBER:  r = (c == C_DIGIT);
            PK_SYMBOL:  r = (c == C_DIGIT) || (c == C_ALPHA) || (c == C_UNDER);
            PK_OPCODE:  r = (c == C_OPCH);
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic pend_t run_start(input cls_t c);
        pend_t r;
        case (c)
            C_BSLASH:        r = PK_LITERAL;
            C_HASH:          r = PK_COMMENT;
            C_DIGIT:         r = PK_NUMBER;
            C_ALPHA, C_UNDER: r = PK_SYMBOL;
            C_OPCH:          r = PK_OPCODE;
            default:         r = PK_NONE;
        endcase
        return r;
    endfunction

    // one-byte token kind; valid only where is_single is true
    function automatic kind_t single_kind(input cls_t c);
        kind_t r;
        case (c)
            C_LF:       r = K_NEWLINE;
            C_LPAREN:   r = K_LPAREN;
            C_RPAREN:   r = K_RPAREN;
            C_LBRACKET: r = K_LBRACKET;
            C_RBRACKET: r = K_RBRACKET;
            C_LBRACE:   r = K_LBRACE;
            C_RBRACE:   r = K_RBRACE;
            C_COMMA:    r = K_COMMA;
            C_SEMI:     r = K_SEMICOLON;
            default:    r = K_ERROR;
        endcase
        return r;
    endfunction

    function automatic logic is_single(input cls_t c);
        return (c != C_SPACE) && (run_start(c) == PK_NONE);
    endfunction

    function automatic kind_t pend_kind(input pend_t pk);
        kind_t r;
        case (pk)
            PK_LITERAL: r = K_LITERAL;
            PK_COMMENT: r = K_NEWLINE;
            PK_NUMBER:  r = K_NUMBER;
            PK_SYMBOL:  r = K_SYMBOL;
            default:    r = K_OPCODE;
        endcase
        return r;
    endfunction

    function automatic pos_t sat_inc(input pos_t p);
        return (p == POS_MAX) ? p : pos_t'(p + pos_t'(1));
    endfunction

    // low bits of an offset, zero-extended if the offset is narrower
    function automatic logic [OUT_POS_BITS-1:0] out_pos(input pos_t p);
        logic [POS_BITS+OUT_POS_BITS-1:0] w;
        w = {{OUT_POS_BITS{1'b0}}, p};
        return w[OUT_POS_BITS-1:0];
    endfunction

endpackage

/* rtl/stt_lexer.sv */
// Tokenizer state (pending run, start and current offsets) and per-byte token logic.
module stt_lexer import stt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  char_beat_t beat,
    output push_t      push
);

    pend_t pend_reg, pend_next;
    pos_t  start_reg, start_next;
    pos_t  pos_reg, pos_next;

    cls_t  cls;
    pos_t  pos_inc;
    logic  has_pend;
    logic  single;
    tok_t  flush_tok;
    tok_t  eof_tok;
    tok_t  single_tok;

    always_comb
    begin
        cls      = classify(beat.ch);
        pos_inc  = sat_inc(pos_reg);
        has_pend = (pend_reg != PK_NONE);
        single   = is_single(cls);

        flush_tok  = '{kind: pend_kind(pend_reg), begin_pos: out_pos(start_reg),
                       end_pos: out_pos(pos_reg), last: 1'b0};
        eof_tok    = '{kind: K_EOF, begin_pos: out_pos(pos_reg),
                       end_pos: out_pos(pos_reg), last: 1'b1};
        single_tok = '{kind: single_kind(cls), begin_pos: out_pos(pos_reg),
                       end_pos: out_pos(pos_inc), last: 1'b1};

        pend_next   = pend_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        push.count  = 2'd0;
        push.first  = flush_tok;
        push.second = eof_tok;

        if (accept)
        begin
            if (beat.is_end)
            begin
                // flush, eof, then offsets restart at zero
                if (has_pend)
                begin
                    push.count = 2'd2;
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = eof_tok;
                end
                pend_next  = PK_NONE;
                start_next = '0;
                pos_next   = '0;
            end
            else if (continues(pend_reg, cls))
            begin
                pos_next = pos_inc;
            end
            else
            begin
                pend_next = run_start(cls);
                if (pend_next != PK_NONE)
                begin
                    start_next = pos_reg;
                end
                pos_next = pos_inc;
                if (has_pend && single)
                begin
                    push.count  = 2'd2;
                    push.second = single_tok;
                end
                else if (has_pend)
                begin
                    push.count      = 2'd1;
                    push.first.last = 1'b1;
                end
                else if (single)
                begin
                    push.count = 2'd1;
                    push.first = single_tok;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= PK_NONE;
            start_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

/* rtl/stt_outq.sv */
// Token queue: takes up to two tokens a cycle, hands out one per output beat.
module stt_outq import stt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  tok_valid,
    input  logic  tok_ready,
    output tok_t  tok_beat
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    tok_t             q_mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] wr_ptr_second;
    logic             pop;

    assign tok_valid     = (cnt_reg != '0);
    assign tok_beat      = q_mem[rd_ptr_reg];
    assign pop           = tok_valid && tok_ready;
    // need space for a worst-case two-token byte
    assign room          = (cnt_reg <= CNT_W'(Q_DEPTH - 2));
    assign wr_ptr_second = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            q_mem[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/source_text_tokenizer_top.sv */
// Top level of the streaming source text tokenizer.
//
// Source bytes arrive one per beat on the char channel; a beat with is_end set
// closes the text. Each token leaves on the tok channel as kind, begin and end
// offset, with last set on the final token that a given input beat caused.
// Run tokens (number, symbol, literal, comment, opcode) are reported on the
// beat that ends them, so a byte can cause up to two tokens (the finished run
// plus a one-byte token, or the flushed run plus eof). The block takes one
// byte per cycle: the per-byte work is a single pass of classification and
// state update, and tokens land the next cycle in a 4-entry queue that feeds
// the output. char_ready is low while fewer than two queue slots are free, so
// a stream of bytes that each cause at most one token runs at one beat per
// cycle, while a byte that causes two tokens takes two output beats to drain.
// Offsets saturate at 65535; after the end beat they restart at zero. No
// clearing pass or warm-up follows reset.
module source_text_tokenizer_top import stt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  char_beat_t char_beat,
    output logic       tok_valid,
    input  logic       tok_ready,
    output tok_t       tok_beat
);

    logic  accept;
    logic  room;
    push_t push;

    assign char_ready = room;
    assign accept     = char_valid && char_ready;

    // pending-token state and token generation
    stt_lexer u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (char_beat),
        .push   (push)
    );

    // output queue decouples a stalled consumer from the byte stream
    stt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_beat  (tok_beat)
    );

endmodule

/* rtl/stt_checker.sv */
// Port-level checks for the tokenizer top level, bound onto it.
module stt_checker import stt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       char_valid,
    input logic       char_ready,
    input char_beat_t char_beat,
    input logic       tok_valid,
    input logic       tok_ready,
    input tok_t       tok_beat
);

    // a stalled token beat holds
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_beat))
        else $error("token beat changed while stalled");

    // eof closes its input beat and spans no bytes
    a_eof_form: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_beat.kind == K_EOF) |->
            tok_beat.last && (tok_beat.begin_pos == tok_beat.end_pos))
        else $error("malformed eof token");

    // offsets never run backward within a token
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> (tok_beat.end_pos >= tok_beat.begin_pos))
        else $error("token ends before it begins");

    // an empty output queue always has room, so the input is never stalled while no token waits
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !tok_valid |-> char_ready)
        else $error("input stalled with empty output");

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (.*);

/* test/tb.sv */
// Self-checking testbench for the source text tokenizer: directed table, then random texts.
module tb;
    import stt_pkg::*;

    // Cycles with no beat on either channel before the run is declared hung.
    // The slowest legal stretch is the single long receiver hold-off plus
    // a long sender gap and two long receiver stalls; this is several times that.
    localparam int QUIET_LIMIT   = 4000;
    localparam int PRESS_CYCLES  = 400;  // receiver hold-off that backs up the queue
    localparam int PRESS_AFTER   = 150;  // tokens seen before the hold-off starts
    localparam int RANDOM_BEATS  = 1150;
    localparam int DRAIN_CYCLES  = 12;

    // byte classes used to build random text
    localparam int BY_DIGIT  = 0;
    localparam int BY_LETTER = 1;
    localparam int BY_WORD   = 2;  // letter, digit or underscore
    localparam int BY_ALNUM  = 3;
    localparam int BY_OP     = 4;
    localparam int BY_SINGLE = 5;
    localparam int BY_BLANK  = 6;
    localparam int BY_BAD    = 7;  // bytes that give an error token
    localparam int BY_ANY    = 8;

    localparam int SIDE_TX = 0;
    localparam int SIDE_RX = 1;

    logic       clk;
    logic       rst_n;
    logic       char_valid;
    logic       char_ready;
    char_beat_t char_beat;
    logic       tok_valid;
    logic       tok_ready;
    tok_t       tok_beat;

    source_text_tokenizer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_beat  (char_beat),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_beat   (tok_beat)
    );

    // ------------------------------------------------------------------
    // Tokenizer shadow state and expected-token store
    // ------------------------------------------------------------------
    pend_t              open_run;   // run token in progress
    logic [POS_BITS-1:0] open_from; // offset of its first byte
    logic [POS_BITS-1:0] text_pos;  // offset of the next byte

    tok_t fresh_toks [2];           // tokens caused by the latest beat
    int   fresh_n;
    tok_t want_toks [$];            // tokens still owed by the DUT

    // directed rows may carry a hand-written expectation instead
    logic typed_row;
    tok_t typed_tok;

    int fail_count;
    int quiet_cycles;
    int toks_seen;
    int beats_sent;
    int calm_left [2];

    logic [7:0] text_bytes [$];

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
        logic       typed;
        kind_t      kind;
        logic [15:0] bpos;
        logic [15:0] epos;
    } step_row_t;

    step_row_t script [$];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [POS_BITS-1:0] step_pos(input logic [POS_BITS-1:0] p);
        return (p == {POS_BITS{1'b1}}) ? p : p + 1'b1;
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_op_byte(input logic [7:0] c);
        logic r;
        case (c)
            // ! " $ % & ' * + - . / : < = > ? @ ^ ` | ~
            8'h21, 8'h22, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D,
            8'h2E, 8'h2F, 8'h3A, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5E,
            8'h60, 8'h7C, 8'h7E: r = 1'b1;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic run_goes_on(input pend_t pk, input logic [7:0] c);
        logic r;
        case (pk)
            PK_LITERAL: r = is_dec(c) || is_letter(c);
            PK_COMMENT: r = (c != CH_LF);
            PK_NUMBER:  r = is_dec(c);
            PK_SYMBOL:  r = is_dec(c) || is_letter(c) || (c == CH_UNDER);
            PK_OPCODE:  r = is_op_byte(c);
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic kind_t run_tok_kind(input pend_t pk);
        kind_t k;
        case (pk)
            PK_LITERAL: k = K_LITERAL;
            PK_COMMENT: k = K_NEWLINE;
            PK_NUMBER:  k = K_NUMBER;
            PK_SYMBOL:  k = K_SYMBOL;
            default:    k = K_OPCODE;
        endcase
        return k;
    endfunction

    function automatic void push_tok(input kind_t k, input logic [POS_BITS-1:0] b,
                                     input logic [POS_BITS-1:0] e);
        tok_t t;
        t.kind      = k;
        t.begin_pos = OUT_POS_BITS'(b);
        t.end_pos   = OUT_POS_BITS'(e);
        t.last      = 1'b0;
        fresh_toks[fresh_n] = t;
        fresh_n++;
    endfunction

    function automatic void close_run();
        if (open_run != PK_NONE)
            push_tok(run_tok_kind(open_run), open_from, text_pos);
        open_run = PK_NONE;
    endfunction

    // advance the shadow state by one accepted beat, leaving its tokens in fresh_toks
    function automatic void tokenize_byte(input char_beat_t b);
        kind_t one;
        logic  has_one;
        fresh_n = 0;
        one     = K_ERROR;
        has_one = 1'b0;
        if (b.is_end) begin
            close_run();
            push_tok(K_EOF, text_pos, text_pos);
            open_from = '0;
            text_pos  = '0;
        end
        else if (run_goes_on(open_run, b.ch)) begin
            text_pos = step_pos(text_pos);
        end
        else begin
            close_run();
            has_one = 1'b1;
            case (b.ch)
                CH_SPACE, CH_TAB: has_one = 1'b0;
                CH_LF:       one = K_NEWLINE;
                CH_LPAREN:   one = K_LPAREN;
                CH_RPAREN:   one = K_RPAREN;
                CH_LBRACKET: one = K_LBRACKET;
                CH_RBRACKET: one = K_RBRACKET;
                CH_LBRACE:   one = K_LBRACE;
                CH_RBRACE:   one = K_RBRACE;
                CH_COMMA:    one = K_COMMA;
                CH_SEMI:     one = K_SEMICOLON;
                CH_BSLASH:
                begin
                    has_one  = 1'b0;
                    open_run = PK_LITERAL;
                end
                CH_HASH:
                begin
                    has_one  = 1'b0;
                    open_run = PK_COMMENT;
                end
                default:
                begin
                    has_one = 1'b0;
                    if (is_dec(b.ch))
                        open_run = PK_NUMBER;
                    else if (is_letter(b.ch) || b.ch == CH_UNDER)
                        open_run = PK_SYMBOL;
                    else if (is_op_byte(b.ch))
                        open_run = PK_OPCODE;
                    else
                    begin
                        has_one = 1'b1;
                        one     = K_ERROR;
                    end
                end
            endcase
            if (open_run != PK_NONE)
                open_from = text_pos;
            if (has_one)
                push_tok(one, text_pos, step_pos(text_pos));
            text_pos = step_pos(text_pos);
        end
        if (fresh_n > 0)
            fresh_toks[fresh_n-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // mostly short gaps, a few long ones, and now and then a stretch of none
    function automatic int pick_gap(input int side);
        int r;
        int g;
        g = 0;
        if (calm_left[side] > 0)
            calm_left[side]--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                calm_left[side] = $urandom_range(20, 80);
            else if (r < 65)
                g = 0;
            else if (r < 95)
                g = $urandom_range(1, 3);
            else
                g = $urandom_range(8, 40);
        end
        return g;
    endfunction

    function automatic logic [7:0] class_byte(input int cls);
        logic [7:0] c;
        int r;
        case (cls)
            BY_DIGIT:  c = 8'("0" + $urandom_range(0, 9));
            BY_LETTER:
            begin
                r = $urandom_range(0, 52);
                if (r == 52)
                    c = CH_UNDER;
                else if (r < 26)
                    c = 8'("a" + r);
                else
                    c = 8'("A" + r - 26);
            end
            BY_WORD:
            begin
                r = $urandom_range(0, 2);
                c = (r == 0) ? class_byte(BY_DIGIT) : class_byte(BY_LETTER);
            end
            BY_ALNUM:
            begin
                r = $urandom_range(0, 2);
                if (r == 0)
                    c = class_byte(BY_DIGIT);
                else
                    c = r[0] ? 8'("a" + $urandom_range(0, 25)) : 8'("A" + $urandom_range(0, 25));
            end
            BY_OP:
            begin
                case ($urandom_range(0, 20))
                    0:  c = 8'h21;  1:  c = 8'h22;  2:  c = 8'h24;  3:  c = 8'h25;
                    4:  c = 8'h26;  5:  c = 8'h27;  6:  c = 8'h2A;  7:  c = 8'h2B;
                    8:  c = 8'h2D;  9:  c = 8'h2E;  10: c = 8'h2F;  11: c = 8'h3A;
                    12: c = 8'h3C;  13: c = 8'h3D;  14: c = 8'h3E;  15: c = 8'h3F;
                    16: c = 8'h40;  17: c = 8'h5E;  18: c = 8'h60;  19: c = 8'h7C;
                    default: c = 8'h7E;
                endcase
            end
            BY_SINGLE:
            begin
                case ($urandom_range(0, 8))
                    0: c = CH_LPAREN;   1: c = CH_RPAREN;
                    2: c = CH_LBRACKET; 3: c = CH_RBRACKET;
                    4: c = CH_LBRACE;   5: c = CH_RBRACE;
                    6: c = CH_COMMA;    7: c = CH_SEMI;
                    default: c = CH_LF;
                endcase
            end
            BY_BLANK:  c = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
            BY_BAD:
            begin
                case ($urandom_range(0, 2))
                    0:       c = 8'($urandom_range(0, 8));
                    1:       c = 8'($urandom_range(11, 31));
                    default: c = 8'($urandom_range(127, 255));
                endcase
            end
            default:   c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // append one well-formed token (or a bit of noise) to text_bytes;
    // no forced separator, so neighboring runs cut each other off
    function automatic void add_fragment();
        int r;
        int n;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 14)
        begin
            n = $urandom_range(1, 5);
            repeat (n) text_bytes.push_back(class_byte(BY_DIGIT));
        end
        else if (r < 30)
        begin
            text_bytes.push_back(class_byte(BY_LETTER));
            n = $urandom_range(0, 5);
            repeat (n) text_bytes.push_back(class_byte(BY_WORD));
        end
        else if (r < 38)
        begin
            text_bytes.push_back(CH_BSLASH);
            n = $urandom_range(0, 4);
            repeat (n) text_bytes.push_back(class_byte(BY_ALNUM));
        end
        else if (r < 46)
        begin
            text_bytes.push_back(CH_HASH);
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                c = class_byte(BY_ANY);
                text_bytes.push_back((c == CH_LF) ? CH_SPACE : c);
            end
            if ($urandom_range(0, 2) != 0)
                text_bytes.push_back(CH_LF);
        end
        else if (r < 58)
        begin
            n = $urandom_range(1, 4);
            repeat (n) text_bytes.push_back(class_byte(BY_OP));
        end
        else if (r < 72)
            text_bytes.push_back(class_byte(BY_SINGLE));
        else if (r < 88)
        begin
            n = $urandom_range(1, 2);
            repeat (n) text_bytes.push_back(class_byte(BY_BLANK));
        end
        else if (r < 94)
            text_bytes.push_back(class_byte(BY_BAD));
        else
            text_bytes.push_back(class_byte(BY_ANY));
    endfunction

    function automatic step_row_t step_row(input logic [7:0] ch, input logic is_end,
                                           input logic typed, input kind_t kind,
                                           input int bpos, input int epos);
        step_row_t s;
        s.ch     = ch;
        s.is_end = is_end;
        s.typed  = typed;
        s.kind   = kind;
        s.bpos   = 16'(bpos);
        s.epos   = 16'(epos);
        return s;
    endfunction

    // drive one beat after a random gap and hold it until accepted
    task automatic send_beat(input char_beat_t b, input logic typed, input tok_t t);
        int gap;
        gap = pick_gap(SIDE_TX);
        @(negedge clk);
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        typed_row = typed;
        typed_tok = t;
        char_valid <= 1'b1;
        char_beat  <= b;
        forever
        begin
            @(posedge clk);
            if (char_ready)
                break;
        end
        beats_sent++;
    endtask

    task automatic send_text();
        char_beat_t b;
        foreach (text_bytes[i])
        begin
            b.ch     = text_bytes[i];
            b.is_end = 1'b0;
            send_beat(b, 1'b0, '0);
        end
        b.ch     = 8'($urandom_range(0, 255));  // ignored on the end beat
        b.is_end = 1'b1;
        send_beat(b, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Clock, receiver, monitor, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: one ready decision per falling edge. Once enough tokens have
    // gone by it holds off for a long stretch so the queue fills and the
    // input side has to stall.
    initial
    begin
        int  off_left;
        logic pressed;
        off_left  = 0;
        pressed   = 1'b0;
        tok_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && !pressed && toks_seen >= PRESS_AFTER)
            begin
                pressed  = 1'b1;
                off_left = PRESS_CYCLES;
            end
            if (!rst_n || off_left > 0)
            begin
                tok_ready <= 1'b0;
                if (off_left > 0)
                    off_left--;
            end
            else
            begin
                tok_ready <= 1'b1;
                off_left = pick_gap(SIDE_RX);
            end
        end
    end

    // Monitor: predicts on every accepted char beat, checks every accepted token.
    always @(posedge clk)
    begin
        tok_t w;
        logic busy;
        if (rst_n)
        begin
            busy = 1'b0;
            if (char_valid && char_ready)
            begin
                busy = 1'b1;
                tokenize_byte(char_beat);
                if (typed_row)
                    want_toks.push_back(typed_tok);
                else
                    for (int i = 0; i < fresh_n; i++)
                        want_toks.push_back(fresh_toks[i]);
            end
            if (tok_valid && tok_ready)
            begin
                busy = 1'b1;
                toks_seen++;
                if (want_toks.size() == 0)
                begin
                    $error("unexpected token: kind %0d begin %0d end %0d last %0d",
                           tok_beat.kind, tok_beat.begin_pos, tok_beat.end_pos,
                           tok_beat.last);
                    fail_count++;
                end
                else
                begin
                    w = want_toks.pop_front();
                    if (tok_beat.kind !== w.kind)
                    begin
                        $error("kind: expected %0d, got %0d", w.kind, tok_beat.kind);
                        fail_count++;
                    end
                    if (tok_beat.begin_pos !== w.begin_pos)
                    begin
                        $error("begin_pos: expected %0d, got %0d", w.begin_pos,
                               tok_beat.begin_pos);
                        fail_count++;
                    end
                    if (tok_beat.end_pos !== w.end_pos)
                    begin
                        $error("end_pos: expected %0d, got %0d", w.end_pos, tok_beat.end_pos);
                        fail_count++;
                    end
                    if (tok_beat.last !== w.last)
                    begin
                        $error("last: expected %0d, got %0d", w.last, tok_beat.last);
                        fail_count++;
                    end
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        char_beat_t b;
        tok_t       t;
        int         len;
        int         goal;

        rst_n        = 1'b0;
        char_valid   = 1'b0;
        char_beat    = '0;
        typed_row    = 1'b0;
        typed_tok    = '0;
        fail_count   = 0;
        quiet_cycles = 0;
        toks_seen    = 0;
        beats_sent   = 0;
        calm_left[SIDE_TX] = 0;
        calm_left[SIDE_RX] = 0;
        open_run  = PK_NONE;
        open_from = '0;
        text_pos  = '0;

        // Directed part. Typed rows start right after reset, so each one-byte
        // token sits at a known offset; the rest go through the predictor.
        script.push_back(step_row(8'hFF, 1'b1, 1'b1, K_EOF, 0, 0)); // eof at reset, ch ignored
        script.push_back(step_row(CH_LPAREN,   1'b0, 1'b1, K_LPAREN,    0, 1));
        script.push_back(step_row(CH_RPAREN,   1'b0, 1'b1, K_RPAREN,    1, 2));
        script.push_back(step_row(CH_LBRACKET, 1'b0, 1'b1, K_LBRACKET,  2, 3));
        script.push_back(step_row(CH_RBRACKET, 1'b0, 1'b1, K_RBRACKET,  3, 4));
        script.push_back(step_row(CH_LBRACE,   1'b0, 1'b1, K_LBRACE,    4, 5));
        script.push_back(step_row(CH_RBRACE,   1'b0, 1'b1, K_RBRACE,    5, 6));
        script.push_back(step_row(CH_COMMA,    1'b0, 1'b1, K_COMMA,     6, 7));
        script.push_back(step_row(CH_SEMI,     1'b0, 1'b1, K_SEMICOLON, 7, 8));
        script.push_back(step_row(CH_LF,       1'b0, 1'b1, K_NEWLINE,   8, 9));
        script.push_back(step_row(8'h00,       1'b0, 1'b1, K_ERROR,     9, 10));
        script.push_back(step_row(8'hFF,       1'b0, 1'b1, K_ERROR,    10, 11));
        script.push_back(step_row(8'h0D,       1'b0, 1'b1, K_ERROR,    11, 12)); // carriage return
        // number, cut off by a symbol start
        script.push_back(step_row("9",         1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row("0",         1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row("x",         1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row(CH_UNDER,    1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row("Z",         1'b0, 1'b0, K_ERROR, 0, 0));
        // literal, then opcode, then comment over a high byte and a tab
        script.push_back(step_row(CH_BSLASH,   1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row("q",         1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row("!",         1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row("~",         1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row(CH_HASH,     1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row(8'h80,       1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row(CH_TAB,      1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row(CH_LF,       1'b0, 1'b0, K_ERROR, 0, 0)); // comment + newline
        script.push_back(step_row(CH_SPACE,    1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row("A",         1'b0, 1'b0, K_ERROR, 0, 0));
        script.push_back(step_row(8'h00,       1'b1, 1'b0, K_ERROR, 0, 0)); // flush + eof

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            b.ch        = script[i].ch;
            b.is_end    = script[i].is_end;
            t.kind      = script[i].kind;
            t.begin_pos = script[i].bpos;
            t.end_pos   = script[i].epos;
            t.last      = 1'b1;
            send_beat(b, script[i].typed, t);
        end

        // Random texts of well-formed tokens in random order, each closed by
        // an end beat; some are empty so end beats also come back to back.
        goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < goal)
        begin
            text_bytes.delete();
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
            while (text_bytes.size() < len)
                add_fragment();
            send_text();
        end

        @(negedge clk);
        char_valid <= 1'b0;

        while (want_toks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
